// ===== rtl/ssml_pkg.sv =====
// Shared types and constants for the name table lookup block.
// No dependencies; used by every module in rtl/ except ssml_ram.
`default_nettype none

package ssml_pkg;

    localparam int BUCKETS  = 25;
    localparam int ENTRIES  = 1024;
    localparam int NAME_LEN = 128;

    localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int JW  = $clog2(NAME_LEN);
    localparam int LW  = $clog2(NAME_LEN + 1);
    localparam int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    localparam int STORE_AW    = EW + JW;
    localparam int STORE_DEPTH = ENTRIES << JW;

    // height % BUCKETS by reciprocal multiply, exact for 8-bit heights
    localparam int MOD_SH    = 16;
    localparam int MOD_PW    = MOD_SH + 9;
    localparam int MOD_RECIP = (1 << MOD_SH) / BUCKETS + 1;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] height;
        logic [7:0] name_char;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic        stored;
        logic        table_full;
        logic        name_truncated;
        logic [4:0]  bucket_index;
        logic [10:0] bucket_fill;
    } t_out_item;

    typedef struct packed {
        t_in_item         item;
        logic [BKW-1:0]   bucket;
    } t_cls_item;

endpackage

`default_nettype wire

// ===== rtl/ssml_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
`default_nettype none

module ssml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ssml_front.sv =====
// Front stage: takes input items and computes the bucket from height.
// Depends on ssml_pkg.
`default_nettype none

module ssml_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire ssml_pkg::t_in_item  i_item,
    output logic                     o_full,
    output logic                     o_push,
    output ssml_pkg::t_cls_item      o_item,
    input  wire logic                i_q_full
);

    logic                         r_valid;
    ssml_pkg::t_in_item           r_item;
    logic [7:0]                   r_quot;
    logic                         advance;
    logic [ssml_pkg::MOD_PW-1:0]  prod;
    logic [15:0]                  rem;

    assign advance = !r_valid || !i_q_full;
    assign prod    = ssml_pkg::MOD_PW'(i_item.height)
                   * ssml_pkg::MOD_PW'(ssml_pkg::MOD_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_push;
        end
        if (advance) begin
            r_item <= i_item;
            r_quot <= prod[ssml_pkg::MOD_SH +: 8];
        end
    end

    assign rem = 16'(r_item.height) - 16'(r_quot) * 16'(ssml_pkg::BUCKETS);

    assign o_full        = !advance;
    assign o_push        = r_valid;
    assign o_item.item   = r_item;
    assign o_item.bucket = rem[ssml_pkg::BKW-1:0];

endmodule

`default_nettype wire

// ===== rtl/ssml_queue.sv =====
// Short item queue between front and back.
// Depends on ssml_pkg.
`default_nettype none

module ssml_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire ssml_pkg::t_cls_item  i_item,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output ssml_pkg::t_cls_item       o_item
);

    ssml_pkg::t_cls_item          r_mem [ssml_pkg::QDEPTH];
    logic [ssml_pkg::QAW-1:0]     r_wp;
    logic [ssml_pkg::QAW-1:0]     r_rp;
    logic [ssml_pkg::QAW:0]       r_cnt;
    logic                         wr;
    logic                         rd;

    assign o_full  = (r_cnt == (ssml_pkg::QAW+1)'(ssml_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ssml_back.sv =====
// Back end: collects name bytes, commits inserts, searches stored names.
// Depends on ssml_pkg and ssml_ram.
`default_nettype none

module ssml_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_empty,
    input  wire ssml_pkg::t_cls_item  i_q_item,
    output logic                      o_q_pop,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output ssml_pkg::t_out_item       o_item
);

    localparam logic [2:0] S_RUN = 3'd0;
    localparam logic [2:0] S_LEN = 3'd1;
    localparam logic [2:0] S_LCK = 3'd2;
    localparam logic [2:0] S_BRD = 3'd3;
    localparam logic [2:0] S_BCK = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [ssml_pkg::CW-1:0]   r_cnt, n_cnt;
    logic [ssml_pkg::LW-1:0]   r_plen, n_plen;
    logic                      r_ovf, n_ovf;
    logic [ssml_pkg::CW-1:0]   r_e, n_e;
    logic [ssml_pkg::JW-1:0]   r_j, n_j;
    logic                      r_out_valid, n_out_valid;
    ssml_pkg::t_out_item       r_out, n_out;
    logic [ssml_pkg::CW-1:0]   r_bcnt [ssml_pkg::BUCKETS];

    ssml_pkg::t_cls_item       head;
    logic                      take;
    logic                      room;
    logic                      has_slot;
    logic [ssml_pkg::LW-1:0]   plen_new;
    logic                      ovf_new;
    logic [ssml_pkg::CW-1:0]   bcnt_cur;
    logic [ssml_pkg::CW-1:0]   fill;
    logic                      bcnt_we;

    logic                          st_we;
    logic [ssml_pkg::STORE_AW-1:0] st_addr;
    logic [7:0]                    st_rdata;
    logic                          pd_we;
    logic [ssml_pkg::JW-1:0]       pd_addr;
    logic [7:0]                    pd_rdata;
    logic                          ln_we;
    logic [ssml_pkg::EW-1:0]       ln_addr;
    logic [ssml_pkg::LW-1:0]       ln_rdata;

    assign head     = i_q_item;
    assign take     = (r_state == S_RUN) && !i_q_empty && (!head.item.last || !r_out_valid);
    assign room     = r_plen < ssml_pkg::LW'(ssml_pkg::NAME_LEN);
    assign has_slot = r_cnt < ssml_pkg::CW'(ssml_pkg::ENTRIES);
    assign plen_new = room ? r_plen + 1'b1 : r_plen;
    assign ovf_new  = r_ovf || !room;
    assign bcnt_cur = r_bcnt[head.bucket];
    assign fill     = has_slot ? bcnt_cur + 1'b1 : bcnt_cur;
    assign bcnt_we  = take && head.item.last && (head.item.mode == ssml_pkg::MODE_INSERT)
                   && has_slot;

    // bytes go straight into the next free entry as well as the pending buffer
    assign st_we   = take && room && has_slot;
    assign pd_we   = take && room;
    assign ln_we   = bcnt_we;
    assign st_addr = (r_state == S_RUN)
                   ? {r_cnt[ssml_pkg::EW-1:0], r_plen[ssml_pkg::JW-1:0]}
                   : {r_e[ssml_pkg::EW-1:0], r_j};
    assign pd_addr = (r_state == S_RUN) ? r_plen[ssml_pkg::JW-1:0] : r_j;
    assign ln_addr = (r_state == S_RUN) ? r_cnt[ssml_pkg::EW-1:0] : r_e[ssml_pkg::EW-1:0];

    ssml_ram #(.WIDTH(8), .DEPTH(ssml_pkg::STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_addr  (st_addr),
        .i_wdata (head.item.name_char),
        .o_rdata (st_rdata)
    );

    ssml_ram #(.WIDTH(8), .DEPTH(ssml_pkg::NAME_LEN)) u_pending (
        .i_clk   (i_clk),
        .i_we    (pd_we),
        .i_addr  (pd_addr),
        .i_wdata (head.item.name_char),
        .o_rdata (pd_rdata)
    );

    ssml_ram #(.WIDTH(ssml_pkg::LW), .DEPTH(ssml_pkg::ENTRIES)) u_lengths (
        .i_clk   (i_clk),
        .i_we    (ln_we),
        .i_addr  (ln_addr),
        .i_wdata (plen_new),
        .o_rdata (ln_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_plen      = r_plen;
        n_ovf       = r_ovf;
        n_e         = r_e;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_RUN: begin
                if (take) begin
                    n_plen = plen_new;
                    n_ovf  = ovf_new;
                    if (head.item.last) begin
                        if (head.item.mode == ssml_pkg::MODE_INSERT) begin
                            n_out_valid          = 1'b1;
                            n_out.found          = 1'b0;
                            n_out.stored         = has_slot;
                            n_out.table_full     = !has_slot;
                            n_out.name_truncated = ovf_new;
                            n_out.bucket_index   = 5'(head.bucket);
                            n_out.bucket_fill    = 11'(fill);
                            n_plen               = '0;
                            n_ovf                = 1'b0;
                            if (has_slot) begin
                                n_cnt = r_cnt + 1'b1;
                            end
                        end else begin
                            n_out.found          = 1'b0;
                            n_out.stored         = 1'b0;
                            n_out.table_full     = 1'b0;
                            n_out.name_truncated = ovf_new;
                            n_out.bucket_index   = '0;
                            n_out.bucket_fill    = '0;
                            n_e                  = '0;
                            n_state              = S_LEN;
                        end
                    end
                end
            end
            S_LEN: begin
                if (r_e == r_cnt) begin
                    n_out_valid = 1'b1;
                    n_plen      = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_RUN;
                end else begin
                    n_state = S_LCK;
                end
            end
            S_LCK: begin
                if (ln_rdata == r_plen) begin
                    n_j     = '0;
                    n_state = S_BRD;
                end else begin
                    n_e     = r_e + 1'b1;
                    n_state = S_LEN;
                end
            end
            S_BRD: begin
                n_state = S_BCK;
            end
            S_BCK: begin
                if (st_rdata != pd_rdata) begin
                    n_e     = r_e + 1'b1;
                    n_state = S_LEN;
                end else if (ssml_pkg::LW'(r_j) + 1'b1 == r_plen) begin
                    n_out.found = 1'b1;
                    n_out_valid = 1'b1;
                    n_plen      = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_RUN;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_BRD;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_cnt       <= '0;
            r_plen      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ssml_pkg::BUCKETS; i++) begin
                r_bcnt[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_plen      <= n_plen;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (bcnt_we) begin
                r_bcnt[head.bucket] <= fill;
            end
        end
        r_e   <= n_e;
        r_j   <= n_j;
        r_out <= n_out;
    end

    assign o_q_pop = take;
    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// ===== rtl/string_set_membership_lookup_top.sv =====
// Name table lookup, top level: front stage, item queue, back end.
// Depends on ssml_pkg, ssml_front, ssml_queue, ssml_back (and ssml_ram).
// Throughput: one character item per cycle outside query searches; a final
// item waits for the previous result to be popped. A query search holds the
// back end per stored entry and per equal-length byte (single read port).
// Reset is synchronous and clears counts at once; no clearing pass.
`default_nettype none

module string_set_membership_lookup_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    input  wire ssml_pkg::t_in_item   i_in_item,
    output logic                      full,
    output logic                      empty,
    input  wire logic                 pop,
    output ssml_pkg::t_out_item       o_out_item
);

    logic                  f_push;
    ssml_pkg::t_cls_item   f_item;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    ssml_pkg::t_cls_item   q_item;

    ssml_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_in_item),
        .o_full   (full),
        .o_push   (f_push),
        .o_item   (f_item),
        .i_q_full (q_full)
    );

    ssml_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    ssml_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_out_item)
    );

endmodule

`default_nettype wire
